>>> src/mpsq_pkg.sv
// Shared definitions for the masked pending-signal queue.
// Holds queue sizing, action codes and the count saturation helper.
// No dependencies.
package mpsq_pkg;

	// queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// signal numbers and per-pass delivery limit
	localparam int SIG_LIMIT = 16;
	localparam int MAX_OUT   = 16;
	localparam int SIG_W     = 4;
	localparam int HIT_W     = 5;
	localparam int PCOUNT_W  = 5;
	localparam int PCOUNT_MAX = 31;

	// action codes
	localparam logic [2:0] ACT_RAISE      = 3'd0;
	localparam logic [2:0] ACT_BLOCK_LOC  = 3'd1;
	localparam logic [2:0] ACT_UNBLK_LOC  = 3'd2;
	localparam logic [2:0] ACT_BLOCK_GLB  = 3'd3;
	localparam logic [2:0] ACT_UNBLK_GLB  = 3'd4;
	localparam logic [2:0] ACT_DELIVER    = 3'd5;

	// queue entry type
	typedef logic [SIG_W-1:0] sig_t;

	// clamp the queue occupancy to the width of the reported count
	function automatic logic [PCOUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		if (int'(c) > PCOUNT_MAX) begin
			return PCOUNT_W'(PCOUNT_MAX);
		end else begin
			return PCOUNT_W'(c);
		end
	endfunction

endpackage

>>> src/mpsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpsq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/masked_pending_signal_queue_top.sv
// Top level of the masked pending-signal queue: sequencer, masks and result port.
// Depends on mpsq_pkg and mpsq_ram.
//
// An action is taken when start is high and busy is low. Raise and mask actions
// give their one result in the cycle after the transfer. Busy stays low, so the
// next action can follow at once. A delivery pass reads the queue RAM one entry a
// cycle and compacts kept entries behind the read pointer. It then shows the
// delivered signals one per cycle, or one empty result when none is delivered.
// Busy stays high through the walk and drops as the last result is shown. The
// next action is taken at the edge that ends the last result. Each result sits
// on the outputs for exactly one cycle, marked by result_valid; the receiver
// cannot stall it and must take it then.
module masked_pending_signal_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [4:0] signal_num,
	output logic       result_valid,
	output logic       delivered_valid,
	output logic [3:0] delivered_num,
	output logic       raise_dropped,
	output logic [4:0] pending_count,
	output logic       last
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [mpsq_pkg::CNT_W-1:0]  total_q;
	logic [mpsq_pkg::CNT_W-1:0]  rd_q;
	logic [mpsq_pkg::CNT_W-1:0]  wr_q;
	logic                        rd_vld_q;
	logic [15:0]                 local_q;
	logic [15:0]                 global_q;
	logic [mpsq_pkg::HIT_W-1:0]  hit_cnt_q;
	logic [3:0]                  emit_q;
	mpsq_pkg::sig_t              hit_buf_q [mpsq_pkg::MAX_OUT];

	logic                        accept;
	logic                        sig_ok;
	logic                        can_raise;
	logic                        rd_more;
	logic                        allowed;
	logic                        emit_last;
	logic                        ram_we;
	logic [mpsq_pkg::IDX_W-1:0]  ram_waddr;
	mpsq_pkg::sig_t              ram_wdata;
	mpsq_pkg::sig_t              ram_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign sig_ok    = (signal_num < 5'(mpsq_pkg::SIG_LIMIT));
	assign can_raise = (total_q < mpsq_pkg::CNT_W'(mpsq_pkg::QUEUE_DEPTH));
	assign rd_more   = (rd_q < total_q);
	assign allowed   = local_q[ram_rdata] && global_q[ram_rdata]
		&& (hit_cnt_q < mpsq_pkg::HIT_W'(mpsq_pkg::MAX_OUT));
	assign emit_last = (mpsq_pkg::HIT_W'(emit_q) + 1'b1 == hit_cnt_q);

	// steer the single RAM write port: append on raise, compact during a walk
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = total_q[mpsq_pkg::IDX_W-1:0];
		ram_wdata = signal_num[3:0];
		if (state_q == ST_IDLE) begin
			ram_we = accept && (action == mpsq_pkg::ACT_RAISE) && sig_ok && can_raise;
		end else if (state_q == ST_WALK) begin
			ram_we    = rd_vld_q && !allowed;
			ram_waddr = wr_q[mpsq_pkg::IDX_W-1:0];
			ram_wdata = ram_rdata;
		end
	end

	mpsq_ram #(
		.WIDTH(mpsq_pkg::SIG_W),
		.DEPTH(mpsq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q[mpsq_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// collect delivered signals during the walk
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && rd_vld_q && allowed) begin
			hit_buf_q[hit_cnt_q[3:0]] <= ram_rdata;
		end
	end

	// sequencer, masks, occupancy and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			total_q         <= '0;
			rd_q            <= '0;
			wr_q            <= '0;
			rd_vld_q        <= 1'b0;
			local_q         <= 16'hFFFF;
			global_q        <= 16'hFFFF;
			hit_cnt_q       <= '0;
			emit_q          <= '0;
			result_valid    <= 1'b0;
			delivered_valid <= 1'b0;
			delivered_num   <= '0;
			raise_dropped   <= 1'b0;
			pending_count   <= '0;
			last            <= 1'b0;
		end else begin
			result_valid    <= 1'b0;
			delivered_valid <= 1'b0;
			delivered_num   <= '0;
			raise_dropped   <= 1'b0;
			last            <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == mpsq_pkg::ACT_DELIVER) begin
							rd_q      <= '0;
							wr_q      <= '0;
							rd_vld_q  <= 1'b0;
							hit_cnt_q <= '0;
							state_q   <= ST_WALK;
						end else begin
							// single plain result for every other action
							result_valid  <= 1'b1;
							last          <= 1'b1;
							pending_count <= mpsq_pkg::sat_count(total_q);
							if (sig_ok) begin
								case (action)
									mpsq_pkg::ACT_RAISE: begin
										if (can_raise) begin
											total_q       <= total_q + 1'b1;
											pending_count <= mpsq_pkg::sat_count(
												total_q + 1'b1);
										end else begin
											raise_dropped <= 1'b1;
										end
									end
									mpsq_pkg::ACT_BLOCK_LOC:
										local_q[signal_num[3:0]] <= 1'b0;
									mpsq_pkg::ACT_UNBLK_LOC:
										local_q[signal_num[3:0]] <= 1'b1;
									mpsq_pkg::ACT_BLOCK_GLB:
										global_q[signal_num[3:0]] <= 1'b0;
									mpsq_pkg::ACT_UNBLK_GLB:
										global_q[signal_num[3:0]] <= 1'b1;
									default: ;
								endcase
							end
						end
					end
				end
				ST_WALK: begin
					// issue the next read while the previous one is judged
					rd_vld_q <= rd_more;
					if (rd_more) begin
						rd_q <= rd_q + 1'b1;
					end
					if (rd_vld_q) begin
						if (allowed) begin
							hit_cnt_q <= hit_cnt_q + 1'b1;
						end else begin
							wr_q <= wr_q + 1'b1;
						end
					end
					if (!rd_more && !rd_vld_q) begin
						total_q <= wr_q;
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// show one delivered signal a cycle, or one empty result
					result_valid  <= 1'b1;
					pending_count <= mpsq_pkg::sat_count(total_q);
					if (hit_cnt_q == '0) begin
						last    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						delivered_valid <= 1'b1;
						delivered_num   <= hit_buf_q[emit_q];
						emit_q          <= emit_q + 1'b1;
						if (emit_last) begin
							last    <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
